// ----- rtl/tcw_pkg.sv -----
// Shared types, constants and the helper function of the text console writer.
package tcw_pkg;

  // Screen geometry and tab spacing.
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STEP = 4;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int ADDR_W   = $clog2(CELLS);

  // Cursor register widths and their one-bit-wider working copies.
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ROWX_W = ROW_W + 1;
  localparam int COLX_W = COL_W + 1;

  // First cell of the bottom row and the last destination of a scroll copy.
  localparam int BOTTOM_START = (ROWS - 1) * COLUMNS;
  localparam int SCROLL_LAST  = BOTTOM_START - 1;

  // Field widths of the channels.
  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int RADDR_W = 11;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_TEXT_ATTR = 1'b0;
  localparam logic [ATTR_W-1:0] TEXT_ATTR_RESET = 8'h07;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Control characters.
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;

  // A blank cell is a space on light grey.
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  char_code;
    logic [RADDR_W-1:0] read_address;
  } in_beat_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] read_data;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_SCROLL_END,
    ST_FILL,
    ST_DONE
  } state_t;

  // Linear cell index of a row and column.
  function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    int idx;
    idx = int'(row) * COLUMNS + int'(col);
    return ADDR_W'(idx);
  endfunction

endpackage

// ----- rtl/tcw_apb_regs.sv -----
// APB-style configuration register file holding the text attribute.
module tcw_apb_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tcw_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [tcw_pkg::ATTR_W-1:0]      text_attr
);
  import tcw_pkg::*;

  logic [ATTR_W-1:0] text_attr_r;
  logic [ATTR_W-1:0] text_attr_nxt;
  logic              wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_TEXT_ATTR);

  always_comb begin
    text_attr_nxt = text_attr_r;
    if (wr_hit) begin
      text_attr_nxt = pwdata[ATTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= TEXT_ATTR_RESET;
    end else begin
      text_attr_r <= text_attr_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TEXT_ATTR) begin
      prdata = CFG_DATA_W'(text_attr_r);
    end
  end

  assign text_attr = text_attr_r;

endmodule

// ----- rtl/tcw_engine.sv -----
// Cell store, cursor and the sequencer that reads, modifies and writes the store.
module tcw_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  tcw_pkg::in_beat_t           in_beat,
  output logic                        in_stall,
  input  logic [tcw_pkg::ATTR_W-1:0]  text_attr,
  output logic                        res_valid,
  output tcw_pkg::out_beat_t          res_beat,
  input  logic                        res_take
);
  import tcw_pkg::*;

  // Cell store: one write port, one registered read port.
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;

  state_t            state_r, state_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [CELL_W-1:0] res_data_r, res_data_nxt;

  logic              accept;
  logic              rd_in_range;

  // Put-character evaluation.
  logic [ROWX_W-1:0] r1, r2;
  logic [COLX_W-1:0] c1, c2;
  logic              put_wr;
  logic [ADDR_W-1:0] put_addr;
  logic [CELL_W-1:0] put_data;
  logic              put_scroll;
  logic [ROW_W-1:0]  put_row;
  logic [COL_W-1:0]  put_col;

  assign in_stall    = (state_r != ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign rd_in_range = (int'(in_beat.read_address) < CELLS);

  always_comb begin
    r1       = {1'b0, row_r};
    c1       = {1'b0, col_r};
    put_wr   = 1'b0;
    put_addr = cell_index(row_r, col_r);
    put_data = {text_attr, in_beat.char_code};
    case (in_beat.char_code)
      CH_NEWLINE: begin
        r1 = {1'b0, row_r} + ROWX_W'(1);
        c1 = '0;
      end
      CH_BACKSPACE: begin
        put_data = BLANK_CELL;
        if (row_r == '0 && col_r == '0) begin
          put_wr = 1'b0;
        end else if (col_r == '0) begin
          r1       = {1'b0, row_r} - ROWX_W'(1);
          c1       = COLX_W'(COLUMNS - 1);
          put_wr   = 1'b1;
          put_addr = cell_index(row_r - ROW_W'(1), COL_W'(COLUMNS - 1));
        end else begin
          c1       = {1'b0, col_r} - COLX_W'(1);
          put_wr   = 1'b1;
          put_addr = cell_index(row_r, col_r - COL_W'(1));
        end
      end
      CH_TAB: begin
        c1 = {1'b0, col_r} + COLX_W'(TAB_STEP);
      end
      default: begin
        c1     = {1'b0, col_r} + COLX_W'(1);
        put_wr = 1'b1;
      end
    endcase

    r2 = r1;
    c2 = c1;
    if (int'(c1) >= COLUMNS) begin
      r2 = r1 + ROWX_W'(1);
      c2 = '0;
    end
    put_scroll = (int'(r2) >= ROWS);
    if (put_scroll) begin
      put_row = ROW_W'(ROWS - 1);
      put_col = '0;
    end else begin
      put_row = r2[ROW_W-1:0];
      put_col = c2[COL_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (int'(ptr_r) == CELLS - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_beat.kind)
            KIND_PUT:   state_nxt = put_scroll ? ST_SCROLL : ST_DONE;
            KIND_CLEAR: state_nxt = ST_FILL;
            KIND_READ:  state_nxt = ST_READ;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_READ:   state_nxt = ST_DONE;
      ST_SCROLL: begin
        if (int'(ptr_r) == SCROLL_LAST) begin
          state_nxt = ST_SCROLL_END;
        end
      end
      ST_SCROLL_END: state_nxt = ST_FILL;
      ST_FILL: begin
        if (int'(ptr_r) == CELLS - 1) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // Datapath and memory port control.
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    ptr_nxt      = ptr_r;
    wr_pend_nxt  = 1'b0;
    wr_addr_nxt  = wr_addr_r;
    rd_ok_nxt    = rd_ok_r;
    res_data_nxt = res_data_r;
    rd_en        = 1'b0;
    rd_addr      = ADDR_W'(in_beat.read_address);
    wr_en        = 1'b0;
    wr_addr      = ptr_r;
    wr_data      = BLANK_CELL;

    // A copied cell is written in the cycle after its read.
    if (wr_pend_r) begin
      wr_en   = 1'b1;
      wr_addr = wr_addr_r;
      wr_data = rdata_r;
    end

    case (state_r)
      ST_INIT, ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = BLANK_CELL;
        ptr_nxt = ptr_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          res_data_nxt = '0;
          ptr_nxt      = '0;
          case (in_beat.kind)
            KIND_PUT: begin
              wr_en   = put_wr;
              wr_addr = put_addr;
              wr_data = put_data;
              row_nxt = put_row;
              col_nxt = put_col;
            end
            KIND_CLEAR: begin
              row_nxt = '0;
              col_nxt = '0;
            end
            KIND_READ: begin
              rd_en     = rd_in_range;
              rd_ok_nxt = rd_in_range;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        res_data_nxt = rd_ok_r ? rdata_r : '0;
      end
      ST_SCROLL: begin
        rd_en       = 1'b1;
        rd_addr     = ptr_r + ADDR_W'(COLUMNS);
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = ptr_r;
        ptr_nxt     = ptr_r + ADDR_W'(1);
      end
      ST_SCROLL_END: begin
        ptr_nxt = ADDR_W'(BOTTOM_START);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      row_r     <= '0;
      col_r     <= '0;
      ptr_r     <= '0;
      wr_pend_r <= 1'b0;
      rd_ok_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      ptr_r     <= ptr_nxt;
      wr_pend_r <= wr_pend_nxt;
      rd_ok_r   <= rd_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r  <= wr_addr_nxt;
    res_data_r <= res_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign res_valid           = (state_r == ST_DONE);
  assign res_beat.cursor_pos = POS_W'(cell_index(row_r, col_r));
  assign res_beat.read_data  = res_data_r;

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(row_r) < ROWS) && (int'(col_r) < COLUMNS))
    else $error("cursor left the screen");

  a_clear_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_beat.kind == KIND_CLEAR) |=> (state_r == ST_FILL) && (ptr_r == '0))
    else $error("clear item did not start a fill from cell zero");

  a_copy_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (state_r == ST_SCROLL) || (state_r == ST_SCROLL_END))
    else $error("scroll copy write outside the scroll");

  a_read_follows_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> ($past(state_r) == ST_IDLE) && !$past(in_stall))
    else $error("cell read without an accepted read item");

endmodule

// ----- rtl/text_console_writer_top.sv -----
// Top level of the text console writer: configuration port, engine and result register.
//
// The block keeps a screen of 80 x 25 sixteen-bit cells (attribute in the upper
// byte, character in the lower byte) and a cursor, and handles one input beat at a
// time. A put-character beat interprets newline, backspace and tab, or writes the
// configured text attribute with the character at the cursor and advances it; the
// cursor wraps at the right edge, and moving past the bottom row scrolls the screen
// up by one row and blanks the bottom row. A clear beat blanks every cell and homes
// the cursor; a read beat returns one cell. Every input beat yields exactly one
// result beat that carries the cursor position after the item (after any scroll)
// and, for read beats, the cell contents. The cell memory has one write port and one
// read port with a registered read, each touching one cell per cycle. A beat that
// scrolls copies 1920 cells up by one row and then blanks the 80 bottom-row cells; a
// clear beat blanks all 2000 cells. After reset the block blanks the memory in a pass
// over all 2000 cells before it accepts its first beat; configuration writes are
// taken at any time. Results sit in an output register, so the engine can accept the
// next beat while the previous result waits for the receiver.
module text_console_writer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel.
  input  logic                            in_valid,
  input  tcw_pkg::in_beat_t               in_beat,
  output logic                            in_stall,
  // Result channel.
  output logic                            out_valid,
  output tcw_pkg::out_beat_t              out_beat,
  input  logic                            out_stall,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tcw_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import tcw_pkg::*;

  logic [ATTR_W-1:0] text_attr;
  logic              res_valid;
  out_beat_t         res_beat;
  logic              res_take;

  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_beat_r, out_beat_nxt;

  // The text attribute register; it is sampled by the engine at each put beat.
  tcw_apb_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .text_attr (text_attr)
  );

  // The engine owns the cell memory, the cursor and the sequencer.
  tcw_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_beat   (in_beat),
    .in_stall  (in_stall),
    .text_attr (text_attr),
    .res_valid (res_valid),
    .res_beat  (res_beat),
    .res_take  (res_take)
  );

  // The result register takes a new beat when it is empty or being drained.
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_beat_nxt  = out_beat_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_beat_nxt  = res_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule
